/* rtl/packet_pool_and_drop_queue_unit_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef PACKET_POOL_AND_DROP_QUEUE_UNIT_MACROS_SVH
`define PACKET_POOL_AND_DROP_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge while out of reset.
`define PPDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define PPDQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define PPDQ_ASSERT(lbl, prop, msg)
`define PPDQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/ppdq_pkg.sv */
`default_nettype none

package ppdq_pkg;

    localparam int POOL_SIZE   = 16;
    localparam int QUEUE_DEPTH = 16;

    localparam int HANDLE_W   = 4;
    localparam int QIDX_W     = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [QIDX_W-1:0]   t_qidx;
    typedef logic [COUNT_W-1:0]  t_count;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_PUSH  = 2'd2,
        REQ_POP   = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_POOL_EMPTY = 3'd1,
        ST_POOL_FULL  = 3'd2,
        ST_Q_OVERFLOW = 3'd3,
        ST_Q_EMPTY    = 3'd4
    } t_status;

    localparam logic [1:0] POL_REPORT        = 2'd0;
    localparam logic [1:0] POL_DROP_OLDEST   = 2'd1;
    localparam logic [1:0] POL_DROP_INCOMING = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DROP_POLICY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY = 1'b1;

    // Free-list link memory access
    typedef struct packed {
        logic    we;
        t_handle waddr;
        t_handle wdata;
        t_handle raddr;
    } t_fl_port;

    // Queue slot memory access
    typedef struct packed {
        logic    we;
        t_qidx   waddr;
        t_handle wdata;
        t_qidx   raddr;
    } t_ring_port;

    // Link value of a free-list entry that was never written
    function automatic t_handle fl_reset_link(input t_handle h);
        fl_reset_link = (h == '0) ? '0 : t_handle'(h - t_handle'(1));
    endfunction

endpackage

`default_nettype wire

/* rtl/ppdq_req_if.sv */
`default_nettype none

interface ppdq_req_if;
    import ppdq_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    t_handle    handle_in;

    modport source (output valid, output req_type, output handle_in, input ready);
    modport sink   (input valid, input req_type, input handle_in, output ready);
endinterface

`default_nettype wire

/* rtl/ppdq_rsp_if.sv */
`default_nettype none

interface ppdq_rsp_if;
    import ppdq_pkg::*;

    logic    valid;
    logic    ready;
    t_handle handle_out;
    t_status status;
    logic    dropped_oldest;
    t_count  free_count;
    t_count  queue_count;
    logic    front_valid;
    t_handle front_handle;

    modport source (
        output valid, output handle_out, output status, output dropped_oldest,
        output free_count, output queue_count, output front_valid,
        output front_handle, input ready
    );
    modport sink (
        input valid, input handle_out, input status, input dropped_oldest,
        input free_count, input queue_count, input front_valid,
        input front_handle, output ready
    );
endinterface

`default_nettype wire

/* rtl/packet_pool_and_drop_queue_unit.sv */
// Packet handle pool with a bounded ring queue.
// i_req carries one request per beat: allocate, free, push or pop, plus a
// handle for free and push. o_rsp returns exactly one result beat per request
// with the status, the allocated or popped handle, and the pool level, queue
// level and queue front after the request.
// The configuration port writes drop_policy (index 0) and queue_capacity
// (index 1) with i_cfg_we; write it only while no request is in flight.
// A request passes through S_IDLE, S_MOD, S_EXEC and S_OUT from accept to
// accept: S_IDLE takes the beat, S_MOD reduces the ring index modulo the
// capacity, S_EXEC read-modify-writes the link and slot memories, and S_OUT
// loads the result register. A drop-oldest push reduces two indices in S_MOD.
// After capacity shrinks while entries are queued, S_MOD repeats the
// subtraction until the index is below the capacity.
// Reset restores the full pool, an empty queue and the default configuration
// at once; requests are taken from the first cycle after reset.
// While the receiver stalls, the result is held in the output register and
// the next request is taken and worked up to its result, then held.
`default_nettype none

module packet_pool_and_drop_queue_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    ppdq_req_if.sink                                i_req,
    ppdq_rsp_if.source                              o_rsp,
    input  wire logic                               i_cfg_we,
    input  wire logic [ppdq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ppdq_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import ppdq_pkg::*;

`include "packet_pool_and_drop_queue_unit_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    localparam t_count POOL_CNT  = t_count'(POOL_SIZE);
    localparam t_count DEPTH_CNT = t_count'(QUEUE_DEPTH);
    localparam t_count ONE_CNT   = t_count'(1);

    t_state     r_state;
    logic [1:0] r_policy;
    t_count     r_cap;

    t_handle    r_free_top;
    t_count     r_free_rem;
    t_qidx      r_head;
    t_count     r_len;

    t_req_type  r_req;
    t_handle    r_hin;
    t_count     r_mod;
    logic       r_pass;
    t_qidx      r_tail;
    t_qidx      r_nhead;
    t_handle    r_hout;
    t_status    r_status;
    logic       r_dropped;

    logic       r_o_valid;
    t_handle    r_o_handle;
    t_status    r_o_status;
    logic       r_o_dropped;
    t_count     r_o_free_cnt;
    t_count     r_o_q_cnt;
    logic       r_o_front_vld;
    t_handle    r_o_front;

    t_handle    n_free_top;
    t_count     n_free_rem;
    t_qidx      n_head;
    t_count     n_len;
    t_handle    n_hout;
    t_status    n_status;
    logic       n_dropped;

    t_fl_port   w_fl;
    t_ring_port w_ring;
    t_handle    w_link;
    t_handle    w_slot;

    t_count     w_cap;
    t_count     w_mod_sub;
    logic       w_qfull;
    logic       w_pfull;
    logic       w_drop;
    logic       w_accept;
    logic       w_load;

    ppdq_free_list u_free_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_port  (w_fl),
        .o_link  (w_link)
    );

    ppdq_ring u_ring (
        .i_clk   (i_clk),
        .i_port  (w_ring),
        .o_rdata (w_slot)
    );

    // Effective capacity: zero acts as one, oversize clamps to depth
    assign w_cap = (r_cap == '0) ? ONE_CNT : ((r_cap > DEPTH_CNT) ? DEPTH_CNT : r_cap);

    assign w_qfull   = (r_len >= w_cap);
    assign w_pfull   = (r_free_rem >= POOL_CNT);
    assign w_drop    = (r_req == REQ_PUSH) && w_qfull && (r_policy == POL_DROP_OLDEST)
                       && !w_pfull;
    assign w_mod_sub = (r_mod >= w_cap) ? t_count'(r_mod - w_cap) : r_mod;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load      = (r_state == S_OUT) && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = (r_state == S_IDLE);

    // Request execution against the memory read data
    always_comb begin
        n_free_top   = r_free_top;
        n_free_rem   = r_free_rem;
        n_head       = r_head;
        n_len        = r_len;
        n_hout       = '0;
        n_status     = ST_OK;
        n_dropped    = 1'b0;
        w_fl.we      = 1'b0;
        w_fl.waddr   = r_hin;
        w_fl.wdata   = r_free_top;
        w_ring.we    = 1'b0;
        w_ring.waddr = r_tail;
        w_ring.wdata = r_hin;
        if (r_state == S_EXEC) begin
            case (r_req)
                REQ_ALLOC: begin
                    if (r_free_rem == '0) begin
                        n_status = ST_POOL_EMPTY;
                    end else begin
                        n_hout     = r_free_top;
                        n_free_top = w_link;
                        n_free_rem = t_count'(r_free_rem - ONE_CNT);
                    end
                end
                REQ_FREE: begin
                    if (w_pfull) begin
                        n_status = ST_POOL_FULL;
                    end else begin
                        w_fl.we    = 1'b1;
                        n_free_top = r_hin;
                        n_free_rem = t_count'(r_free_rem + ONE_CNT);
                    end
                end
                REQ_PUSH: begin
                    if (!w_qfull) begin
                        w_ring.we = 1'b1;
                        n_len     = t_count'(r_len + ONE_CNT);
                    end else begin
                        case (r_policy)
                            POL_DROP_OLDEST: begin
                                if (w_pfull) begin
                                    n_status = ST_POOL_FULL;
                                end else begin
                                    // return the old front to the pool, append at tail
                                    w_fl.we    = 1'b1;
                                    w_fl.waddr = w_slot;
                                    n_free_top = w_slot;
                                    n_free_rem = t_count'(r_free_rem + ONE_CNT);
                                    n_head     = r_nhead;
                                    w_ring.we  = 1'b1;
                                    n_dropped  = 1'b1;
                                end
                            end
                            POL_DROP_INCOMING: begin
                                if (w_pfull) begin
                                    n_status = ST_POOL_FULL;
                                end else begin
                                    w_fl.we    = 1'b1;
                                    n_free_top = r_hin;
                                    n_free_rem = t_count'(r_free_rem + ONE_CNT);
                                end
                            end
                            default: begin
                                n_status = ST_Q_OVERFLOW;
                            end
                        endcase
                    end
                end
                REQ_POP: begin
                    if (r_len == '0) begin
                        n_status = ST_Q_EMPTY;
                    end else begin
                        n_hout = w_slot;
                        n_len  = t_count'(r_len - ONE_CNT);
                        n_head = (r_len == ONE_CNT) ? '0 : r_nhead;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
        w_fl.raddr   = r_free_top;
        w_ring.raddr = n_head;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_policy   <= POL_REPORT;
            r_cap      <= DEPTH_CNT;
            r_free_top <= t_handle'(POOL_SIZE - 1);
            r_free_rem <= POOL_CNT;
            r_head     <= '0;
            r_len      <= '0;
            r_pass     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DROP_POLICY:    r_policy <= i_cfg_wdata[1:0];
                    CFG_QUEUE_CAPACITY: r_cap    <= t_count'(i_cfg_wdata);
                    default:            r_policy <= r_policy;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pass  <= 1'b0;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (w_mod_sub < w_cap) begin
                        if (!r_pass && (r_req == REQ_PUSH) && w_drop) begin
                            r_pass <= 1'b1;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    r_free_top <= n_free_top;
                    r_free_rem <= n_free_rem;
                    r_head     <= n_head;
                    r_len      <= n_len;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Request payload and index reduction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= t_req_type'(i_req.req_type);
            r_hin <= i_req.handle_in;
            if (t_req_type'(i_req.req_type) == REQ_PUSH) begin
                r_mod <= t_count'(t_count'(r_head) + r_len);
            end else begin
                r_mod <= t_count'(t_count'(r_head) + ONE_CNT);
            end
        end else if (r_state == S_MOD) begin
            if (w_mod_sub < w_cap) begin
                if (!r_pass && (r_req == REQ_PUSH)) begin
                    r_tail <= w_mod_sub[QIDX_W-1:0];
                    // drop-oldest also needs the advanced head
                    r_mod  <= t_count'(t_count'(r_head) + ONE_CNT);
                end else begin
                    r_nhead <= w_mod_sub[QIDX_W-1:0];
                end
            end else begin
                r_mod <= w_mod_sub;
            end
        end

        if (r_state == S_EXEC) begin
            r_hout    <= n_hout;
            r_status  <= n_status;
            r_dropped <= n_dropped;
        end

        if (w_load) begin
            r_o_handle    <= r_hout;
            r_o_status    <= r_status;
            r_o_dropped   <= r_dropped;
            r_o_free_cnt  <= r_free_rem;
            r_o_q_cnt     <= r_len;
            r_o_front_vld <= (r_len != '0);
            r_o_front     <= (r_len != '0) ? w_slot : '0;
        end
    end

    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.handle_out     = r_o_handle;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.dropped_oldest = r_o_dropped;
    assign o_rsp.free_count     = r_o_free_cnt;
    assign o_rsp.queue_count    = r_o_q_cnt;
    assign o_rsp.front_valid    = r_o_front_vld;
    assign o_rsp.front_handle   = r_o_front;

    `PPDQ_ASSERT(a_free_rem_bound, r_free_rem <= POOL_CNT, "free count above pool size")
    `PPDQ_ASSERT(a_len_bound, r_len <= DEPTH_CNT, "queue length above depth")
    `PPDQ_ASSERT(a_tail_in_ring, ((r_state == S_EXEC) && (r_req == REQ_PUSH)) |-> (t_count'(r_tail) < w_cap), "tail index outside capacity")
    `PPDQ_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> ((r_state == S_IDLE) && !r_o_valid), "not idle after reset")

endmodule

`default_nettype wire

/* rtl/ppdq_ring.sv */
`default_nettype none

module ppdq_ring (
    input  wire logic                 i_clk,
    input  wire ppdq_pkg::t_ring_port i_port,
    output ppdq_pkg::t_handle         o_rdata
);
    import ppdq_pkg::*;

    t_handle r_mem [QUEUE_DEPTH];
    t_handle r_rdata;

    // Write-first: a read of the entry being written returns the new value
    always_ff @(posedge i_clk) begin
        if (i_port.we) begin
            r_mem[i_port.waddr] <= i_port.wdata;
        end
        if (i_port.we && (i_port.waddr == i_port.raddr)) begin
            r_rdata <= i_port.wdata;
        end else begin
            r_rdata <= r_mem[i_port.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/ppdq_free_list.sv */
`default_nettype none

module ppdq_free_list (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ppdq_pkg::t_fl_port   i_port,
    output ppdq_pkg::t_handle         o_link
);
    import ppdq_pkg::*;

    t_handle               r_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0]  r_valid;
    logic                  r_rd_valid;
    t_handle               r_rdata;
    t_handle               r_raddr;

    always_ff @(posedge i_clk) begin
        if (i_port.we) begin
            r_mem[i_port.waddr] <= i_port.wdata;
        end
        r_rdata <= r_mem[i_port.raddr];
        r_raddr <= i_port.raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_port.we) begin
                r_valid[i_port.waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_port.raddr];
        end
    end

    // Unwritten entries read as their reset link
    assign o_link = r_rd_valid ? r_rdata : fl_reset_link(r_raddr);

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import ppdq_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 8;
    localparam int STALL_LIMIT      = 3000;
    localparam int MISMATCH_REPORTS = 10;
    localparam int SEGMENT_ITEMS    = 90;
    localparam int NUM_SEGMENTS     = 9;

    // Policy code with no name in the package; the block treats it as report overflow.
    localparam logic [1:0] POL_RESERVED = 2'd3;

    typedef struct packed {
        t_handle handle_out;
        t_status status;
        logic    dropped_oldest;
        t_count  free_count;
        t_count  queue_count;
        logic    front_valid;
        t_handle front_handle;
    } pool_result_t;

    // Shadow copy of the handle pool and ring queue; holds the responses still owed.
    class pool_queue_tracker;
        t_handle               link[POOL_SIZE];
        t_handle               pool_top;
        int                    pool_left;
        t_handle               slots[QUEUE_DEPTH];
        int                    head;
        int                    depth;
        logic [1:0]            policy;
        logic [CFG_DATA_W-1:0] capacity;
        pool_result_t          awaited[$];
        int                    failures;

        function new();
            for (int i = 0; i < POOL_SIZE; i++) begin
                link[i] = (i == 0) ? '0 : t_handle'(i - 1);
            end
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                slots[i] = '0;
            end
            pool_top  = t_handle'(POOL_SIZE - 1);
            pool_left = POOL_SIZE;
            head      = 0;
            depth     = 0;
            policy    = POL_REPORT;
            capacity  = CFG_DATA_W'(QUEUE_DEPTH);
            failures  = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DROP_POLICY) begin
                policy = data[1:0];
            end else begin
                capacity = data;
            end
        endfunction

        function void return_to_pool(t_handle h);
            link[h]  = pool_top;
            pool_top = h;
            pool_left++;
        endfunction

        function t_handle dequeue(int cap);
            t_handle h;
            h = slots[head];
            depth--;
            head = (depth == 0) ? 0 : (head + 1) % cap;
            return h;
        endfunction

        function void enqueue(int cap, t_handle h);
            slots[(head + depth) % cap] = h;
            depth++;
        endfunction

        function pool_result_t predict_request(t_req_type op, t_handle h);
            pool_result_t r;
            int           cap;
            r        = '0;
            r.status = ST_OK;
            // Out-of-range capacity clamps to 1 .. QUEUE_DEPTH.
            cap = (capacity == 0) ? 1 : (capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(capacity);
            case (op)
                REQ_ALLOC: begin
                    if (pool_left == 0) begin
                        r.status = ST_POOL_EMPTY;
                    end else begin
                        r.handle_out = pool_top;
                        pool_top     = link[pool_top];
                        pool_left--;
                    end
                end
                REQ_FREE: begin
                    if (pool_left >= POOL_SIZE) r.status = ST_POOL_FULL;
                    else return_to_pool(h);
                end
                REQ_PUSH: begin
                    if (depth < cap) begin
                        enqueue(cap, h);
                    end else if (policy == POL_DROP_OLDEST) begin
                        if (pool_left >= POOL_SIZE) begin
                            r.status = ST_POOL_FULL;
                        end else begin
                            return_to_pool(dequeue(cap));
                            enqueue(cap, h);
                            r.dropped_oldest = 1'b1;
                        end
                    end else if (policy == POL_DROP_INCOMING) begin
                        if (pool_left >= POOL_SIZE) r.status = ST_POOL_FULL;
                        else return_to_pool(h);
                    end else begin
                        r.status = ST_Q_OVERFLOW;
                    end
                end
                default: begin
                    if (depth == 0) r.status = ST_Q_EMPTY;
                    else r.handle_out = dequeue(cap);
                end
            endcase
            r.free_count   = t_count'(pool_left);
            r.queue_count  = t_count'(depth);
            r.front_valid  = (depth != 0);
            r.front_handle = (depth != 0) ? slots[head] : '0;
            awaited.push_back(r);
            return r;
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= MISMATCH_REPORTS) begin
                $display("[%0t] response mismatch:%s", $realtime, what);
            end
        endfunction

        function void check_response(pool_result_t got);
            pool_result_t want;
            string        diff;
            if (awaited.size() == 0) begin
                note_failure(" response with nothing outstanding");
                return;
            end
            want = awaited.pop_front();
            diff = "";
            if (got.handle_out !== want.handle_out)
                diff = {diff, $sformatf(" handle_out exp %0d got %0d",
                                        want.handle_out, got.handle_out)};
            if (got.status !== want.status)
                diff = {diff, $sformatf(" status exp %0d got %0d", want.status, got.status)};
            if (got.dropped_oldest !== want.dropped_oldest)
                diff = {diff, $sformatf(" dropped_oldest exp %0b got %0b",
                                        want.dropped_oldest, got.dropped_oldest)};
            if (got.free_count !== want.free_count)
                diff = {diff, $sformatf(" free_count exp %0d got %0d",
                                        want.free_count, got.free_count)};
            if (got.queue_count !== want.queue_count)
                diff = {diff, $sformatf(" queue_count exp %0d got %0d",
                                        want.queue_count, got.queue_count)};
            if (got.front_valid !== want.front_valid)
                diff = {diff, $sformatf(" front_valid exp %0b got %0b",
                                        want.front_valid, got.front_valid)};
            if (got.front_handle !== want.front_handle)
                diff = {diff, $sformatf(" front_handle exp %0d got %0d",
                                        want.front_handle, got.front_handle)};
            if (diff != "") note_failure(diff);
        endfunction
    endclass

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int src_idle_pct  = 29;
    int sink_idle_pct = 54;
    int quiet_cycles  = 0;

    pool_queue_tracker tracker = new();
    t_handle           held[$];

    ppdq_req_if req_ch();
    ppdq_rsp_if rsp_ch();

    packet_pool_and_drop_queue_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(negedge clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_response('{handle_out:     rsp_ch.handle_out,
                                     status:         rsp_ch.status,
                                     dropped_oldest: rsp_ch.dropped_oldest,
                                     free_count:     rsp_ch.free_count,
                                     queue_count:    rsp_ch.queue_count,
                                     front_valid:    rsp_ch.front_valid,
                                     front_handle:   rsp_ch.front_handle});
        end
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one request beat and track the handles the stimulus holds.
    // Entered and left at a falling edge; valid stays high on return.
    task automatic issue(input t_req_type op, input t_handle h, input int idx);
        pool_result_t r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.handle_in <= h;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) @(posedge clk);
        r = tracker.predict_request(op, h);
        @(negedge clk);
        if (r.status == ST_OK) begin
            if (op == REQ_ALLOC || op == REQ_POP) held.push_back(r.handle_out);
            else if (idx >= 0) held.delete(idx);
        end
        if (held.size() > 2 * POOL_SIZE) void'(held.pop_front());
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (tracker.awaited.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        tracker.write_register(idx, data);
    endtask

    task automatic set_policy(input logic [1:0] pol);
        wait_idle();
        write_reg(CFG_DROP_POLICY, CFG_DATA_W'(pol));
    endtask

    // Empty the queue first so the ring restarts at slot zero under the new capacity.
    task automatic configure(input logic [1:0] pol, input logic [CFG_DATA_W-1:0] cap);
        wait_idle();
        while (tracker.depth > 0) issue(REQ_POP, t_handle'($urandom_range(0, 15)), -1);
        set_policy(pol);
        write_reg(CFG_QUEUE_CAPACITY, cap);
    endtask

    task automatic run_segment(input int n);
        int        pick;
        int        idx;
        bit        filling;
        t_req_type op;
        t_handle   h;
        for (int k = 0; k < n; k++) begin
            pick    = $urandom_range(0, 99);
            filling = ((k / 30) % 2) == 0;
            // Alternate filling and draining so both the empty and the full corners come up.
            if (filling) begin
                op = (pick < 35) ? REQ_ALLOC : (pick < 70) ? REQ_PUSH :
                     (pick < 80) ? REQ_FREE : REQ_POP;
            end else begin
                op = (pick < 10) ? REQ_ALLOC : (pick < 25) ? REQ_PUSH :
                     (pick < 65) ? REQ_FREE : REQ_POP;
            end
            idx = -1;
            h   = t_handle'($urandom_range(0, 15));
            if ((op == REQ_FREE || op == REQ_PUSH) && held.size() > 0 &&
                $urandom_range(0, 99) < 85) begin
                idx = $urandom_range(0, held.size() - 1);
                h   = held[idx];
            end
            issue(op, h, idx);
        end
    endtask

    initial begin
        logic [1:0]            seg_policy[NUM_SEGMENTS];
        logic [CFG_DATA_W-1:0] seg_capacity[NUM_SEGMENTS];
        seg_policy   = '{POL_DROP_OLDEST, POL_DROP_INCOMING, POL_REPORT, POL_RESERVED,
                         POL_DROP_OLDEST, POL_DROP_INCOMING, POL_DROP_OLDEST,
                         POL_REPORT, POL_DROP_OLDEST};
        seg_capacity = '{5'd16, 5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd16, 5'd8};

        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_ALLOC;
        req_ch.handle_in = '0;
        rsp_ch.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_DROP_POLICY;
        cfg_wdata        = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: empty queue, full pool, a round trip through the queue.
        issue(REQ_POP,   4'h0, -1);
        issue(REQ_FREE,  4'hF, -1);
        issue(REQ_ALLOC, 4'h0, -1);
        issue(REQ_ALLOC, 4'h0, -1);
        issue(REQ_PUSH,  4'hF, -1);
        issue(REQ_POP,   4'h0, -1);
        issue(REQ_FREE,  4'hF, -1);
        issue(REQ_PUSH,  4'hE, -1);
        issue(REQ_POP,   4'h0, -1);
        issue(REQ_FREE,  4'hE, -1);

        // One-slot queue: overflow under each full-queue policy.
        configure(POL_REPORT, 5'd1);
        issue(REQ_PUSH,  4'h0, -1);
        issue(REQ_PUSH,  4'h3, -1);
        set_policy(POL_DROP_OLDEST);
        issue(REQ_PUSH,  4'h5, -1);
        issue(REQ_ALLOC, 4'h0, -1);
        issue(REQ_PUSH,  4'h9, -1);
        set_policy(POL_DROP_INCOMING);
        issue(REQ_PUSH,  4'hA, -1);
        issue(REQ_ALLOC, 4'h0, -1);
        issue(REQ_PUSH,  4'hA, -1);
        set_policy(POL_RESERVED);
        issue(REQ_PUSH,  4'h1, -1);
        issue(REQ_POP,   4'h0, -1);

        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            configure(seg_policy[seg], seg_capacity[seg]);
            if (seg == 4) begin
                src_idle_pct  = 54;
                sink_idle_pct = 29;
            end else if (seg == 7) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            run_segment(SEGMENT_ITEMS);
        end

        wait_idle();
        if (tracker.failures == 0 && tracker.awaited.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
